// ===== hdl/bmap_pkg.sv =====
// Shared types and constants for the bitmap set/get/find-next block.
// Used by bitmap_set_get_find_next; depends on nothing else.
`default_nettype none

package bmap_pkg;

  // Bitmap geometry.
  localparam int MAX_BITS    = 4096;
  localparam int WORD_BITS   = 64;
  localparam int STORE_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W     = $clog2(STORE_WORDS);
  localparam int BITSEL_W    = $clog2(WORD_BITS);
  localparam int INDEX_W     = 12;
  localparam int COUNT_W     = 13;

  localparam logic [COUNT_W-1:0] BIT_COUNT_RESET = COUNT_W'(4096);
  localparam logic [COUNT_W-1:0] MAX_COUNT       = COUNT_W'(MAX_BITS);

  // Operation codes carried in the input tuser.
  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACCESS,
    S_SCAN,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/bmap_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package dependencies.
`default_nettype none

module bmap_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bitmap_set_get_find_next.sv =====
// Bitmap of 4096 bits in a 64 x 64 RAM: write a bit, read a bit, find the next set bit.
// Flow: an out-of-range or unused item goes from acceptance straight to the emit state, a read
// or write passes through the access state first, and a search in range scans k words (1..64).
// Throughput: a new item is accepted in the cycle after the result is loaded into the output
// register; the word scan reads one RAM word per cycle.
// Reset: synchronous; bit_count returns to 4096 and per-word valid flops make every word read 0.
`default_nettype none

module bitmap_set_get_find_next (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: bit_count
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [12:0] cfg_data,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // bit_pos[11:0], bit_value[12], from_start[13], 0
  input  wire logic [1:0]  s_axis_tuser,  // mode[1:0]
  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata   // read_bit[0], found[1], found_index[13:2],
                                          // status[14], 0[15]
);

  localparam int WW = bmap_pkg::WADDR_W;
  localparam int BW = bmap_pkg::BITSEL_W;
  localparam int IW = bmap_pkg::INDEX_W;
  localparam int CW = bmap_pkg::COUNT_W;
  localparam int DW = bmap_pkg::WORD_BITS;

  // Position of the lowest set bit by a binary search over halves.
  function automatic logic [BW-1:0] lowest_set(input logic [DW-1:0] v);
    logic [DW-1:0] t;
    logic [BW-1:0] pos;
    t   = v;
    pos = '0;
    for (int k = BW - 1; k >= 0; k--) begin
      if ((t & ((DW'(1) << (1 << k)) - DW'(1))) == '0) begin
        pos[k] = 1'b1;
        t      = t >> (1 << k);
      end
    end
    return pos;
  endfunction

  bmap_pkg::state_t state, state_next;

  logic [CW-1:0]  bit_count;
  logic [1:0]     mode_q;
  logic [IW-1:0]  index_q;
  logic           value_q;
  logic [CW-1:0]  start_q;
  logic [CW-1:0]  count_q;
  logic [WW-1:0]  last_q;
  logic [WW-1:0]  word_q;
  logic [WW-1:0]  rd_addr_q;
  logic [bmap_pkg::STORE_WORDS-1:0] word_vld;

  logic           res_read_bit;
  logic           res_found;
  logic [IW-1:0]  res_index;
  logic           res_status;

  logic           ram_wr_en;
  logic [DW-1:0]  ram_wr_data;
  logic           ram_rd_en;
  logic [WW-1:0]  ram_rd_addr;
  logic [DW-1:0]  ram_rd_data;

  // Unpack the input beat.
  logic           accept;
  logic [1:0]     in_mode;
  logic [IW-1:0]  in_index;
  logic           in_value;
  logic           in_from_start;
  logic [CW-1:0]  count_eff;
  logic           in_oor;
  logic [CW-1:0]  in_start;
  logic           in_scan_ok;
  logic [CW-1:0]  count_m1;

  assign accept        = s_axis_tvalid & s_axis_tready;
  assign in_mode       = s_axis_tuser;
  assign in_index      = s_axis_tdata[IW-1:0];
  assign in_value      = s_axis_tdata[IW];
  assign in_from_start = s_axis_tdata[IW+1];

  assign count_eff  = (bit_count > bmap_pkg::MAX_COUNT) ? bmap_pkg::MAX_COUNT : bit_count;
  assign in_oor     = {1'b0, in_index} >= count_eff;
  assign in_start   = in_from_start ? '0 : ({1'b0, in_index} + CW'(1));
  assign in_scan_ok = (count_eff != '0) && (in_start < count_eff);
  assign count_m1   = count_eff - CW'(1);

  // Word returned by the RAM; a word never written since reset reads as zero.
  logic [DW-1:0] word_data;
  assign word_data = word_vld[rd_addr_q] ? ram_rd_data : '0;

  // Single-bit access on the word just read.
  logic [DW-1:0] bit_mask;
  assign bit_mask    = DW'(1) << index_q[BW-1:0];
  assign ram_wr_data = value_q ? (word_data | bit_mask) : (word_data & ~bit_mask);

  // Scan step: mask the first and last words, then look for a set bit.
  logic [DW-1:0] first_mask;
  logic [DW-1:0] last_mask;
  logic [DW-1:0] scan_word;
  logic          scan_hit;
  logic          scan_end;

  assign first_mask = (word_q == start_q[IW-1:BW]) ? ({DW{1'b1}} << start_q[BW-1:0])
                                                   : {DW{1'b1}};
  assign last_mask  = ((word_q == last_q) && (count_q[BW-1:0] != '0))
                      ? ((DW'(1) << count_q[BW-1:0]) - DW'(1)) : {DW{1'b1}};
  assign scan_word  = word_data & first_mask & last_mask;
  assign scan_hit   = scan_word != '0;
  assign scan_end   = scan_hit || (word_q == last_q);

  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      bmap_pkg::S_IDLE: begin
        if (accept) begin
          case (in_mode)
            bmap_pkg::MODE_WRITE, bmap_pkg::MODE_READ: begin
              state_next = in_oor ? bmap_pkg::S_EMIT : bmap_pkg::S_ACCESS;
            end
            bmap_pkg::MODE_SEARCH: begin
              if (!in_from_start && in_oor) begin
                state_next = bmap_pkg::S_EMIT;
              end else begin
                state_next = in_scan_ok ? bmap_pkg::S_SCAN : bmap_pkg::S_EMIT;
              end
            end
            default: state_next = bmap_pkg::S_EMIT;
          endcase
        end
      end
      bmap_pkg::S_ACCESS: state_next = bmap_pkg::S_EMIT;
      bmap_pkg::S_SCAN: begin
        if (scan_end) begin
          state_next = bmap_pkg::S_EMIT;
        end
      end
      bmap_pkg::S_EMIT: begin
        if (out_free) begin
          state_next = bmap_pkg::S_IDLE;
        end
      end
      default: state_next = bmap_pkg::S_IDLE;
    endcase
  end

  // Handshake and RAM control.
  always_comb begin
    s_axis_tready = 1'b0;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = '0;
    ram_wr_en     = 1'b0;
    case (state)
      bmap_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        ram_rd_en     = s_axis_tvalid;
        ram_rd_addr   = (in_mode == bmap_pkg::MODE_SEARCH) ? in_start[IW-1:BW]
                                                           : in_index[IW-1:BW];
      end
      bmap_pkg::S_ACCESS: begin
        ram_wr_en = (mode_q == bmap_pkg::MODE_WRITE);
      end
      bmap_pkg::S_SCAN: begin
        ram_rd_en   = !scan_end;
        ram_rd_addr = word_q + WW'(1);
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  assign cfg_ready = 1'b1;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= bmap_pkg::S_IDLE;
      bit_count     <= bmap_pkg::BIT_COUNT_RESET;
      word_vld      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        bit_count <= cfg_data;
      end
      if (ram_wr_en) begin
        word_vld[rd_addr_q] <= 1'b1;
      end
      if (state == bmap_pkg::S_EMIT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Item and result registers.
  always_ff @(posedge clk) begin
    if (ram_rd_en) begin
      rd_addr_q <= ram_rd_addr;
    end
    case (state)
      bmap_pkg::S_IDLE: begin
        if (accept) begin
          mode_q       <= in_mode;
          index_q      <= in_index;
          value_q      <= in_value;
          start_q      <= in_start;
          count_q      <= count_eff;
          last_q       <= count_m1[IW-1:BW];
          word_q       <= in_start[IW-1:BW];
          res_read_bit <= 1'b0;
          res_found    <= 1'b0;
          res_index    <= '0;
          res_status   <= (in_mode == bmap_pkg::MODE_WRITE || in_mode == bmap_pkg::MODE_READ)
                          ? in_oor
                          : ((in_mode == bmap_pkg::MODE_SEARCH) && !in_from_start && in_oor);
        end
      end
      bmap_pkg::S_ACCESS: begin
        res_read_bit <= (mode_q == bmap_pkg::MODE_READ) && word_data[index_q[BW-1:0]];
      end
      bmap_pkg::S_SCAN: begin
        if (scan_hit) begin
          res_found <= 1'b1;
          res_index <= {word_q, lowest_set(scan_word)};
        end else if (!scan_end) begin
          word_q <= word_q + WW'(1);
        end
      end
      bmap_pkg::S_EMIT: begin
        if (out_free) begin
          m_axis_tdata <= {1'b0, res_status, res_index, res_found, res_read_bit};
        end
      end
      default: begin
        res_found <= res_found;
      end
    endcase
  end

  bmap_ram #(
    .WIDTH(DW),
    .DEPTH(bmap_pkg::STORE_WORDS)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(rd_addr_q),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // An accepted beat always starts work; the block is never idle right after it.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != bmap_pkg::S_IDLE)
    else $error("block idle right after accepting an item");

  // The scan never runs past the last word in use.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == bmap_pkg::S_SCAN |-> word_q <= last_q)
    else $error("scan passed the last word in use");

  // A found bit always lies below the bit count in force for the item.
  a_found_range: assert property (@(posedge clk) disable iff (rst)
    (state == bmap_pkg::S_EMIT && res_found) |-> ({1'b0, res_index} < count_q))
    else $error("found index at or beyond the bit count");

  // A result never reports a hit together with an out-of-range status.
  a_found_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[1] && m_axis_tdata[14]))
    else $error("found and out-of-range both set");

endmodule

`default_nettype wire

// ===== tb/bitmap_set_get_find_next_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bitmap_set_get_find_next: write, read and find-next beats
// are predicted by an in-bench bitmap and compared with every result beat.
// Depends on bmap_pkg and the bitmap_set_get_find_next RTL.

module bitmap_set_get_find_next_test;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam logic       STATUS_RANGE = 1'b1;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 80;
  localparam int SETTLE_CYCLES  = 4;

  // Packed to match m_axis_tdata[14:0] from the top bit down.
  typedef struct packed {
    logic                         status;
    logic [bmap_pkg::INDEX_W-1:0] found_index;
    logic                         found;
    logic                         read_bit;
  } bitmap_result_t;

  logic                         clk;
  logic                         rst           = 1'b1;
  logic                         cfg_valid     = 1'b0;
  logic                         cfg_ready;
  logic [bmap_pkg::COUNT_W-1:0] cfg_data      = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [15:0]                  s_axis_tdata  = '0;  // bit_pos[11:0], bit_value[12],
                                                     // from_start[13], 0
  logic [1:0]                   s_axis_tuser  = '0;  // mode[1:0]
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [15:0]                  m_axis_tdata;        // read_bit[0], found[1],
                                                     // found_index[13:2], status[14], 0[15]

  // Predicted contents of the block and the results still owed by it.
  logic [bmap_pkg::WORD_BITS-1:0] bitmap_model [bmap_pkg::STORE_WORDS];
  int unsigned                    bit_count_model;
  bitmap_result_t                 pending_results [$];

  int  error_count     = 0;
  int  items_sent      = 0;
  int  results_checked = 0;
  int  hits_found      = 0;
  int  count_writes    = 0;
  int  cycle_count     = 0;
  bit  no_gaps         = 1'b0;
  bit  rx_hold_req     = 1'b0;

  bitmap_set_get_find_next dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one operation to the bitmap and work out the result it must give.
  function automatic bitmap_result_t predict_bitmap_op(logic [1:0] mode, int unsigned idx,
                                                       logic val, logic fs);
    bitmap_result_t res;
    int unsigned    limit;
    int unsigned    start;
    res   = '0;
    limit = (bit_count_model > bmap_pkg::MAX_BITS) ? bmap_pkg::MAX_BITS : bit_count_model;
    case (mode)
      bmap_pkg::MODE_WRITE, bmap_pkg::MODE_READ: begin
        if (idx >= limit) begin
          res.status = STATUS_RANGE;
        end else if (mode == bmap_pkg::MODE_WRITE) begin
          bitmap_model[idx / bmap_pkg::WORD_BITS][idx % bmap_pkg::WORD_BITS] = val;
        end else begin
          res.read_bit = bitmap_model[idx / bmap_pkg::WORD_BITS][idx % bmap_pkg::WORD_BITS];
        end
      end
      bmap_pkg::MODE_SEARCH: begin
        if (!fs && idx >= limit) begin
          res.status = STATUS_RANGE;
        end else begin
          // Lowest set bit in [start, limit); stale bits above the count never show.
          start = fs ? 0 : idx + 1;
          for (int unsigned p = start; p < limit; p++) begin
            if (bitmap_model[p / bmap_pkg::WORD_BITS][p % bmap_pkg::WORD_BITS]) begin
              res.found       = 1'b1;
              res.found_index = bmap_pkg::INDEX_W'(p);
              break;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Mostly the shortest gap, sometimes a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 1;
    if (r < 92) return $urandom_range(2, 4);
    return $urandom_range(10, 40);
  endfunction

  // Offer one beat, wait for it to be taken, then record what it must produce.
  // Valid stays high when no gap follows, so the next call continues the burst.
  task automatic send_item(logic [1:0] mode, logic [bmap_pkg::INDEX_W-1:0] idx,
                           logic val, logic fs);
    bitmap_result_t expected;
    int             gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {2'b00, fs, val, idx};
    do @(posedge clk); while (!s_axis_tready);
    expected = predict_bitmap_op(mode, idx, val, fs);
    pending_results.push_back(expected);
    items_sent++;
    gap = 0;
    if (!no_gaps && $urandom_range(0, 2) == 0) gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering beats and let every owed result come back.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_bit_count(logic [bmap_pkg::COUNT_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    bit_count_model = value;
    count_writes++;
  endtask

  // Random operations, with indexes mostly inside the active count and
  // some on the boundaries or anywhere in the field.
  task automatic send_random_items(int count, int density);
    logic [1:0]                   mode;
    logic [bmap_pkg::INDEX_W-1:0] idx;
    int unsigned                  limit;
    int                           r;
    for (int k = 0; k < count; k++) begin
      limit = (bit_count_model > bmap_pkg::MAX_BITS) ? bmap_pkg::MAX_BITS : bit_count_model;
      r = $urandom_range(0, 99);
      if (r < 40)      mode = bmap_pkg::MODE_WRITE;
      else if (r < 65) mode = bmap_pkg::MODE_READ;
      else if (r < 95) mode = bmap_pkg::MODE_SEARCH;
      else             mode = MODE_UNUSED;
      r = $urandom_range(0, 99);
      if (r < 75 && limit > 0) begin
        idx = bmap_pkg::INDEX_W'($urandom_range(0, limit - 1));
      end else if (r < 85) begin
        idx = bmap_pkg::INDEX_W'($urandom_range(0, bmap_pkg::MAX_BITS - 1));
      end else begin
        case ($urandom_range(0, 4))
          0:       idx = bmap_pkg::INDEX_W'(limit - 1);
          1:       idx = bmap_pkg::INDEX_W'(limit);
          2:       idx = '0;
          3:       idx = '1;
          default: idx = bmap_pkg::INDEX_W'($urandom_range(0, bmap_pkg::STORE_WORDS - 1)
                                            * bmap_pkg::WORD_BITS + 63);
        endcase
      end
      send_item(mode, idx, $urandom_range(0, 99) < density, $urandom_range(0, 3) == 0);
    end
  endtask

  // Single bits at both ends of the full map, word boundaries, the unused
  // mode and from_start outside search mode.
  task automatic test_single_bits();
    send_item(bmap_pkg::MODE_WRITE, 12'd0, 1'b1, 1'b0);
    send_item(bmap_pkg::MODE_WRITE, 12'd4095, 1'b1, 1'b0);
    send_item(bmap_pkg::MODE_READ, 12'd0, 1'b0, 1'b0);
    send_item(bmap_pkg::MODE_READ, 12'd4095, 1'b0, 1'b0);
    send_item(bmap_pkg::MODE_SEARCH, 12'd0, 1'b0, 1'b1);
    send_item(bmap_pkg::MODE_SEARCH, 12'd0, 1'b0, 1'b0);
    send_item(bmap_pkg::MODE_SEARCH, 12'd4095, 1'b0, 1'b0);
    send_item(MODE_UNUSED, 12'd4095, 1'b1, 1'b1);
    send_item(bmap_pkg::MODE_WRITE, 12'd63, 1'b1, 1'b1);
    send_item(bmap_pkg::MODE_READ, 12'd63, 1'b0, 1'b1);
    send_item(bmap_pkg::MODE_WRITE, 12'd64, 1'b1, 1'b0);
    send_item(bmap_pkg::MODE_SEARCH, 12'd62, 1'b0, 1'b0);
    send_item(bmap_pkg::MODE_SEARCH, 12'd63, 1'b0, 1'b0);
    send_item(bmap_pkg::MODE_WRITE, 12'd0, 1'b0, 1'b0);
  endtask

  // Zero count, saturation above the map size, a single bit, and stale bits
  // left above a reduced count.
  task automatic test_bit_count_extremes();
    write_bit_count(13'd0);
    send_item(bmap_pkg::MODE_WRITE, 12'd0, 1'b1, 1'b0);
    send_item(bmap_pkg::MODE_READ, 12'd0, 1'b0, 1'b0);
    send_item(bmap_pkg::MODE_SEARCH, 12'd0, 1'b0, 1'b1);
    send_item(bmap_pkg::MODE_SEARCH, 12'd0, 1'b0, 1'b0);
    write_bit_count(13'd8191);
    send_item(bmap_pkg::MODE_READ, 12'd4095, 1'b0, 1'b0);
    send_item(bmap_pkg::MODE_SEARCH, 12'd4094, 1'b0, 1'b0);
    write_bit_count(13'd1);
    send_item(bmap_pkg::MODE_WRITE, 12'd0, 1'b1, 1'b0);
    send_item(bmap_pkg::MODE_SEARCH, 12'd0, 1'b0, 1'b1);
    send_item(bmap_pkg::MODE_SEARCH, 12'd0, 1'b0, 1'b0);
    write_bit_count(13'd4095);
    send_item(bmap_pkg::MODE_READ, 12'd4095, 1'b0, 1'b0);
    send_item(bmap_pkg::MODE_SEARCH, 12'd4094, 1'b0, 1'b0);
    write_bit_count(13'd65);
    send_item(bmap_pkg::MODE_SEARCH, 12'd63, 1'b0, 1'b0);
    send_item(bmap_pkg::MODE_SEARCH, 12'd64, 1'b0, 1'b0);
  endtask

  // Phases of random traffic, each under its own count and bit density.
  task automatic test_random_phases();
    logic [bmap_pkg::COUNT_W-1:0] counts [10];
    counts = '{13'd4096, 13'd64, 13'd65, 13'd1, 13'd8191, 13'd127, 13'd0,
               bmap_pkg::COUNT_W'($urandom_range(1, bmap_pkg::MAX_BITS)),
               bmap_pkg::COUNT_W'($urandom_range(0, 8191)),
               13'd4096};
    foreach (counts[i]) begin
      write_bit_count(counts[i]);
      send_random_items((counts[i] == 0) ? 30 : 90, $urandom_range(10, 90));
    end
  endtask

  // A stretch with no idling on either side.
  task automatic test_back_to_back();
    no_gaps = 1'b1;
    send_random_items(150, 50);
    no_gaps = 1'b0;
    wait_idle();
  endtask

  // The receiver holds off for a long stretch while beats keep coming.
  task automatic test_output_backpressure();
    rx_hold_req = 1'b1;
    no_gaps     = 1'b1;
    send_random_items(30, 50);
    no_gaps     = 1'b0;
    wait_idle();
  endtask

  // Result receiver: random stalls, none during back-to-back runs, and one long hold.
  initial begin
    int stall;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
        rx_hold_req = 1'b0;
      end else if (no_gaps || $urandom_range(0, 99) < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        stall = pick_gap();
        m_axis_tready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end
    end
  end

  // Compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    bitmap_result_t expected;
    bitmap_result_t actual;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      actual = bitmap_result_t'(m_axis_tdata[14:0]);
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: tdata 0x%h", m_axis_tdata);
        error_count++;
      end else begin
        expected = pending_results.pop_front();
        results_checked++;
        if (expected.found) hits_found++;
        if (actual.read_bit !== expected.read_bit) begin
          $error("read_bit: expected %0d, actual %0d", expected.read_bit, actual.read_bit);
          error_count++;
        end
        if (actual.found !== expected.found) begin
          $error("found: expected %0d, actual %0d", expected.found, actual.found);
          error_count++;
        end
        if (actual.found_index !== expected.found_index) begin
          $error("found_index: expected %0d, actual %0d",
                 expected.found_index, actual.found_index);
          error_count++;
        end
        if (actual.status !== expected.status) begin
          $error("status: expected %0d, actual %0d", expected.status, actual.status);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    foreach (bitmap_model[w]) bitmap_model[w] = '0;
    bit_count_model = bmap_pkg::BIT_COUNT_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_bits();
    test_bit_count_extremes();
    test_random_phases();
    test_back_to_back();
    test_output_backpressure();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d input beats and checked %0d result beats; %0d searches hit a set bit.",
             items_sent, results_checked, hits_found);
    $display("Bit counts written %0d times, from zero through full size to saturation.",
             count_writes);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
